// ----- hdl/button_press_level_classifier_top_defines.svh -----
// Assertion macros shared by the classifier RTL.
`ifndef BUTTON_PRESS_LEVEL_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_PRESS_LEVEL_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bplc check failed");

// Next-cycle implication, checked outside reset.
`define BPLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bplc check failed");

`endif

// ----- hdl/bplc_pkg.sv -----
`timescale 1ns / 1ps

package bplc_pkg;

    // Field widths fixed by the interface.
    localparam int LEVEL_W = 3;
    localparam int THR_W   = 20;
    localparam int DUR_W   = 20;
    localparam int CFG_IDX_W = 3;

    // Number of threshold registers.
    localparam int THR_REGS = 4;

    // Parameter defaults.
    localparam int MAX_LEVELS_DEF = 4;
    localparam int COUNT_BITS_DEF = 20;

    // Reset values of the configuration registers.
    localparam logic             ACTIVE_LEVEL_RST = 1'b0;
    localparam logic [LEVEL_W-1:0] NUM_LEVELS_RST = 3'd4;
    localparam logic [THR_W-1:0] THR_RST [THR_REGS] = '{
        20'd300, 20'd800, 20'd2000, 20'd5000
    };

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LEVEL = 3'd0,
        REG_NUM_LEVELS   = 3'd1,
        REG_THRESHOLD_1  = 3'd2,
        REG_THRESHOLD_2  = 3'd3,
        REG_THRESHOLD_3  = 3'd4,
        REG_THRESHOLD_4  = 3'd5
    } cfg_reg_t;

endpackage

// ----- hdl/button_press_level_classifier_top.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// s_      | in        | s_valid / s_ready       | s_pin_level
// m_      | out       | m_valid / m_ready       | m_pressed, m_press_level, m_released,
//         |           |                         | m_duration_ms, m_top_reached
// cfg_    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// The edge check, hold counter and threshold compares are one layer of logic
// between the state registers and the result register.
// A new word is accepted every cycle as long as the result register is empty or
// is being drained in the same cycle; a stalled sink holds the result and stops input.
// Reset is synchronous, active low, and loads the default thresholds and levels.
// Configuration writes are always accepted.

`include "button_press_level_classifier_top_defines.svh"

module button_press_level_classifier_top #(
    parameter int MAX_LEVELS = bplc_pkg::MAX_LEVELS_DEF,
    parameter int COUNT_BITS = bplc_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Sample input.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_pin_level,
    // Result output.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_pressed,
    output logic [bplc_pkg::LEVEL_W-1:0]   m_press_level,
    output logic                           m_released,
    output logic [bplc_pkg::DUR_W-1:0]     m_duration_ms,
    output logic                           m_top_reached,
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bplc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bplc_pkg::THR_W-1:0]     cfg_data
);

    // Only as many levels as there are threshold registers can be used.
    localparam int LEVEL_LIMIT = (MAX_LEVELS < bplc_pkg::THR_REGS) ?
                                 MAX_LEVELS : bplc_pkg::THR_REGS;
    // Compare width covers both the hold counter and a threshold.
    localparam int CMP_W = (COUNT_BITS > bplc_pkg::THR_W) ? COUNT_BITS : bplc_pkg::THR_W;
    localparam logic [CMP_W-1:0] DUR_MAX = CMP_W'({bplc_pkg::DUR_W{1'b1}});

    // Configuration registers.
    logic                         active_level_reg;
    logic [bplc_pkg::LEVEL_W-1:0] num_levels_reg;
    logic [bplc_pkg::THR_W-1:0]   thr_reg [bplc_pkg::THR_REGS];

    // Press tracking state.
    logic                         last_sample_reg, last_sample_next;
    logic                         primed_reg, primed_next;
    logic                         timing_reg, timing_next;
    logic [COUNT_BITS-1:0]        hold_reg, hold_next;
    logic [bplc_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                         top_note_reg, top_note_next;

    // Result register.
    logic                         m_valid_reg;
    logic                         pressed_reg, pressed_next;
    logic [bplc_pkg::LEVEL_W-1:0] press_level_reg, press_level_next;
    logic                         released_reg, released_next;
    logic [bplc_pkg::DUR_W-1:0]   duration_reg, duration_next;
    logic                         top_reached_reg, top_reached_next;

    logic                         accept;
    logic [bplc_pkg::LEVEL_W-1:0] top_level;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_pressed     = pressed_reg;
    assign m_press_level = press_level_reg;
    assign m_released    = released_reg;
    assign m_duration_ms = duration_reg;
    assign m_top_reached = top_reached_reg;

    // Top level: zero behaves as one, anything past the usable count clamps.
    always_comb begin
        if (num_levels_reg == '0) begin
            top_level = bplc_pkg::LEVEL_W'(1);
        end else if (num_levels_reg > bplc_pkg::LEVEL_W'(LEVEL_LIMIT)) begin
            top_level = bplc_pkg::LEVEL_W'(LEVEL_LIMIT);
        end else begin
            top_level = num_levels_reg;
        end
    end

    // Per-sample update of the press state and the result fields.
    always_comb begin
        logic                         edge_seen;
        logic                         start;
        logic                         rel;
        logic [COUNT_BITS-1:0]        cnt_inc;
        logic [CMP_W-1:0]             cnt_ext;
        logic [bplc_pkg::LEVEL_W-1:0] cand;
        logic [bplc_pkg::LEVEL_W-1:0] lvl;
        logic                         note;

        pressed_next     = (s_pin_level == active_level_reg);
        released_next    = 1'b0;
        duration_next    = '0;
        top_reached_next = 1'b0;
        last_sample_next = s_pin_level;
        primed_next      = 1'b1;
        timing_next      = timing_reg;
        hold_next        = hold_reg;
        level_next       = level_reg;
        top_note_next    = top_note_reg;
        press_level_next = level_reg;

        edge_seen = (s_pin_level != last_sample_reg);
        start     = edge_seen && pressed_next;
        rel       = edge_seen && !pressed_next && timing_reg;
        // The counter saturates at all ones.
        cnt_inc   = (timing_reg && (hold_reg != '1)) ? hold_reg + 1'b1 : hold_reg;
        cnt_ext   = CMP_W'(cnt_inc);
        cand      = '0;
        lvl       = level_reg;
        note      = top_note_reg;

        if (primed_reg) begin
            if (start) begin
                timing_next = 1'b1;
                hold_next   = '0;
                lvl         = '0;
                note        = 1'b0;
            end else if (rel) begin
                timing_next   = 1'b0;
                hold_next     = '0;
                released_next = 1'b1;
                duration_next = (cnt_ext > DUR_MAX) ? bplc_pkg::DUR_W'(DUR_MAX) :
                                                      cnt_ext[bplc_pkg::DUR_W-1:0];
            end else begin
                hold_next = cnt_inc;
            end

            if (!rel && pressed_next && timing_next) begin
                // Highest level in use whose threshold has been met; later wins.
                for (int i = 0; i < LEVEL_LIMIT; i++) begin
                    if ((bplc_pkg::LEVEL_W'(i) < top_level) &&
                        (CMP_W'(hold_next) >= CMP_W'(thr_reg[i]))) begin
                        cand = bplc_pkg::LEVEL_W'(i + 1);
                    end
                end
                if (cand > lvl) begin
                    lvl = cand;
                end
                if ((lvl == top_level) && !note) begin
                    note             = 1'b1;
                    top_reached_next = 1'b1;
                end
            end

            // Report the final level of a finished press before clearing it.
            press_level_next = lvl;
            if (rel) begin
                lvl  = '0;
                note = 1'b0;
            end
            level_next    = lvl;
            top_note_next = note;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= bplc_pkg::ACTIVE_LEVEL_RST;
            num_levels_reg   <= bplc_pkg::NUM_LEVELS_RST;
            thr_reg          <= bplc_pkg::THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bplc_pkg::REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                bplc_pkg::REG_NUM_LEVELS:   num_levels_reg <= cfg_data[bplc_pkg::LEVEL_W-1:0];
                bplc_pkg::REG_THRESHOLD_1:  thr_reg[0] <= cfg_data;
                bplc_pkg::REG_THRESHOLD_2:  thr_reg[1] <= cfg_data;
                bplc_pkg::REG_THRESHOLD_3:  thr_reg[2] <= cfg_data;
                bplc_pkg::REG_THRESHOLD_4:  thr_reg[3] <= cfg_data;
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Press state, updated once per accepted sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg <= 1'b0;
            primed_reg      <= 1'b0;
            timing_reg      <= 1'b0;
            hold_reg        <= '0;
            level_reg       <= '0;
            top_note_reg    <= 1'b0;
        end else if (accept) begin
            last_sample_reg <= last_sample_next;
            primed_reg      <= primed_next;
            timing_reg      <= timing_next;
            hold_reg        <= hold_next;
            level_reg       <= level_next;
            top_note_reg    <= top_note_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; loads only when a new sample is taken.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pressed_reg     <= pressed_next;
            press_level_reg <= press_level_next;
            released_reg    <= released_next;
            duration_reg    <= duration_next;
            top_reached_reg <= top_reached_next;
        end
    end

    `BPLC_ASSERT_NOW(a_release_not_pressed, m_valid_reg && released_reg, !pressed_reg)
    `BPLC_ASSERT_NOW(a_duration_only_on_release, m_valid_reg && !released_reg,
                     duration_reg == '0)
    `BPLC_ASSERT_NOW(a_top_while_pressed, m_valid_reg && top_reached_reg,
                     pressed_reg && (press_level_reg != '0))
    `BPLC_ASSERT_NEXT(a_release_clears_state, accept && primed_reg && released_next,
                      (level_reg == '0) && !timing_reg && !top_note_reg)
    `BPLC_ASSERT_NOW(a_timing_needs_prime, timing_reg, primed_reg)

endmodule

// ----- tb/sv/button_press_level_classifier_top_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the button press level classifier. Each accepted
// sample word is run through a local model of the press timer and level logic.
// The result it predicts is queued, and every result word that leaves the
// block is checked field by field against the oldest queued entry.
module button_press_level_classifier_top_tb;

    // Field widths and register count as the block defines them.
    localparam int LEVEL_W   = bplc_pkg::LEVEL_W;
    localparam int THR_W     = bplc_pkg::THR_W;
    localparam int DUR_W     = bplc_pkg::DUR_W;
    localparam int CFG_IDX_W = bplc_pkg::CFG_IDX_W;
    localparam int THR_REGS  = bplc_pkg::THR_REGS;

    // Half clock period, reset length, the cycle budget for the whole run, and the phases.
    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;

    // The hold counter width and the level cap follow the block's defaults.
    localparam int COUNT_W = bplc_pkg::COUNT_BITS_DEF;
    localparam int TOP_CAP = (bplc_pkg::MAX_LEVELS_DEF < THR_REGS) ?
                             bplc_pkg::MAX_LEVELS_DEF : THR_REGS;
    localparam logic [COUNT_W-1:0] HOLD_SAT = '1;
    localparam logic [DUR_W-1:0]   DUR_SAT  = '1;
    localparam logic [THR_W-1:0]   THR_MAX  = '1;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // One result word, in port order.
    typedef struct packed {
        logic               pressed;
        logic [LEVEL_W-1:0] level;
        logic               released;
        logic [DUR_W-1:0]   duration;
        logic               top;
    } press_report_t;

    // A row of the directed table is either a sample word or a register write.
    typedef enum logic { ROW_SAMPLE = 1'b0, ROW_WRITE = 1'b1 } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 pin;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [THR_W-1:0]     reg_data;
        logic                 typed;
        press_report_t        want;
    } stim_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_pin_level = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_pressed;
    logic [LEVEL_W-1:0]   m_press_level;
    logic                 m_released;
    logic [DUR_W-1:0]     m_duration_ms;
    logic                 m_top_reached;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [THR_W-1:0]     cfg_data    = '0;

    // Copy of the configuration registers, updated on every accepted write.
    logic                 mir_active = bplc_pkg::ACTIVE_LEVEL_RST;
    logic [LEVEL_W-1:0]   mir_levels = bplc_pkg::NUM_LEVELS_RST;
    logic [THR_W-1:0]     mir_thr [THR_REGS] = bplc_pkg::THR_RST;

    // Model state of the press timer, all cleared by reset.
    logic                 pv_last     = 1'b0;
    logic                 pv_primed   = 1'b0;
    logic                 pv_timing   = 1'b0;
    logic [COUNT_W-1:0]   pv_hold     = '0;
    logic [LEVEL_W-1:0]   pv_level    = '0;
    logic                 pv_top_done = 1'b0;

    press_report_t expected_q [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;

    button_press_level_classifier_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pin_level   (s_pin_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pressed     (m_pressed),
        .m_press_level (m_press_level),
        .m_released    (m_released),
        .m_duration_ms (m_duration_ms),
        .m_top_reached (m_top_reached),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Hard stop in case the block hangs or results go missing.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Predicts the result of one sample word and advances the model state.
    // The very first word after reset only records the pin level. After that,
    // a change onto the active level starts a fresh timed press, and a change
    // away from it ends a timed press with its duration and final level.
    function automatic press_report_t classify_sample(input logic pin);
        press_report_t      r;
        logic [LEVEL_W-1:0] top_lvl;
        logic [LEVEL_W-1:0] cand;
        logic               found;
        r = '0;
        // A level count of zero means one; anything above the cap is clipped.
        if (mir_levels == 0)
            top_lvl = LEVEL_W'(1);
        else if (mir_levels > TOP_CAP)
            top_lvl = LEVEL_W'(TOP_CAP);
        else
            top_lvl = mir_levels;
        r.pressed = (pin == mir_active);
        if (!pv_primed) begin
            pv_primed = 1'b1;
            pv_last   = pin;
        end else begin
            if (pv_timing && pv_hold != HOLD_SAT)
                pv_hold = pv_hold + 1'b1;
            if (pin != pv_last) begin
                if (r.pressed) begin
                    pv_timing   = 1'b1;
                    pv_hold     = '0;
                    pv_level    = '0;
                    pv_top_done = 1'b0;
                end else if (pv_timing) begin
                    r.released = 1'b1;
                    r.duration = (pv_hold > DUR_SAT) ? DUR_SAT : DUR_W'(pv_hold);
                    pv_timing  = 1'b0;
                    pv_hold    = '0;
                end
            end
            pv_last = pin;
            // Scan from the highest level in use down; the first threshold that
            // is met wins, and the level may only go up during a press.
            if (!r.released && r.pressed && pv_timing) begin
                cand  = '0;
                found = 1'b0;
                for (int i = THR_REGS - 1; i >= 0; i--) begin
                    if (!found && i < top_lvl && pv_hold >= mir_thr[i]) begin
                        cand  = LEVEL_W'(i + 1);
                        found = 1'b1;
                    end
                end
                if (cand > pv_level)
                    pv_level = cand;
                if (pv_level == top_lvl && !pv_top_done) begin
                    pv_top_done = 1'b1;
                    r.top       = 1'b1;
                end
            end
        end
        // The level of a press that ends now is reported before it is cleared.
        r.level = pv_level;
        if (r.released) begin
            pv_level    = '0;
            pv_top_done = 1'b0;
        end
        return r;
    endfunction

    function automatic stim_row_t row_s(input logic pin);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.pin  = pin;
        return row;
    endfunction

    function automatic stim_row_t row_t(input logic pin, input press_report_t want);
        stim_row_t row;
        row = row_s(pin);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t row_w(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [THR_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind     = ROW_WRITE;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Offers one sample word, with random idle cycles ahead of it when the
    // current phase asks for them. Valid is raised at a falling edge and held
    // until a rising edge sees ready; only then is the expectation queued.
    task automatic send_sample(input logic pin, input logic typed, input press_report_t want);
        press_report_t predicted;
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pin_level <= pin;
        do @(posedge aclk); while (!s_ready);
        predicted = classify_sample(pin);
        expected_q.push_back(typed ? want : predicted);
    endtask

    // Stops offering words, waits until every queued result has come back and
    // then lets the block settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [THR_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bplc_pkg::REG_ACTIVE_LEVEL: mir_active = data[0];
            bplc_pkg::REG_NUM_LEVELS:   mir_levels = data[LEVEL_W-1:0];
            bplc_pkg::REG_THRESHOLD_1, bplc_pkg::REG_THRESHOLD_2,
            bplc_pkg::REG_THRESHOLD_3, bplc_pkg::REG_THRESHOLD_4: begin
                mir_thr[2'(idx - bplc_pkg::REG_THRESHOLD_1)] = data;
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Writes every register for one random phase. The first four phases pin
    // the active level and the level count to known corners, including a count
    // of zero and one above the cap; later phases draw them at random. Upper
    // data bits of the narrow registers carry noise that must be ignored.
    task automatic program_phase(input int phase);
        logic [THR_W-1:0] data;
        int               roll;
        data    = THR_W'($urandom);
        data[0] = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
        write_register(bplc_pkg::REG_ACTIVE_LEVEL, data);
        data = THR_W'($urandom);
        case (phase)
            0:       data[LEVEL_W-1:0] = 3'd4;
            1:       data[LEVEL_W-1:0] = 3'd0;
            2:       data[LEVEL_W-1:0] = 3'd7;
            3:       data[LEVEL_W-1:0] = 3'd1;
            default: data[LEVEL_W-1:0] = LEVEL_W'($urandom_range(0, 7));
        endcase
        write_register(bplc_pkg::REG_NUM_LEVELS, data);
        // Mostly short thresholds so that ordinary presses climb through the
        // levels, with zero, the maximum and longer values mixed in. Nothing
        // keeps them sorted.
        for (int t = 0; t < THR_REGS; t++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                data = THR_W'($urandom_range(0, 20));
            else if (roll < 80)
                data = '0;
            else if (roll < 90)
                data = THR_MAX;
            else
                data = THR_W'($urandom_range(20, 300));
            write_register(CFG_IDX_W'(bplc_pkg::REG_THRESHOLD_1 + t), data);
        end
    endtask

    // Random traffic: mostly clean presses of random length followed by a short
    // release, some with a one-word glitch inside, and a little pure noise.
    // Halfway through, the sender holds off until all results are back.
    task automatic run_random_phase(input int n_items);
        int sent;
        int roll;
        int len;
        int glitch;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end
            end else begin
                len    = (roll < 97) ? $urandom_range(1, 24) : $urandom_range(25, 300);
                glitch = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, len - 1)) : -1;
                for (int j = 0; j < len; j++) begin
                    send_sample((j == glitch) ? !mir_active : mir_active, 1'b0, '0);
                    sent++;
                end
                len = $urandom_range(1, 6);
                repeat (len) begin
                    send_sample(!mir_active, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Result side: ready is chosen at each falling edge, and a word is taken
    // at the rising edge where valid and ready are both high.
    initial begin : result_sink
        press_report_t got;
        press_report_t want;
        forever begin
            @(negedge aclk);
            m_ready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_pressed, m_press_level, m_released, m_duration_ms, m_top_reached};
                if (expected_q.size() == 0) begin
                    $display({"%0t: expected no result, got pressed=%0b level=%0d",
                              " released=%0b dur=%0d top=%0b"},
                             $time, got.pressed, got.level, got.released, got.duration,
                             got.top);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("pressed", 32'(want.pressed), 32'(got.pressed));
                    check_field("press_level", 32'(want.level), 32'(got.level));
                    check_field("released", 32'(want.released), 32'(got.released));
                    check_field("duration_ms", 32'(want.duration), 32'(got.duration));
                    check_field("top_reached", 32'(want.top), 32'(got.top));
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t dir_rows [$];

        repeat (RESET_TICKS) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table. The first rows run on the reset settings (active low,
        // long default thresholds) and their results are typed in: the pin is
        // already pressed at the priming word, so nothing is timed until it is
        // released and pressed again, and that press ends after one word.
        // The remaining rows use tiny thresholds and rely on the model.
        dir_rows = '{
            row_t(1'b0, '{1'b1, 3'd0, 1'b0, 20'd0, 1'b0}),
            row_t(1'b0, '{1'b1, 3'd0, 1'b0, 20'd0, 1'b0}),
            row_t(1'b1, '{1'b0, 3'd0, 1'b0, 20'd0, 1'b0}),
            row_t(1'b0, '{1'b1, 3'd0, 1'b0, 20'd0, 1'b0}),
            row_t(1'b1, '{1'b0, 3'd0, 1'b1, 20'd1, 1'b0}),
            row_w(bplc_pkg::REG_ACTIVE_LEVEL, 20'd1),
            row_w(bplc_pkg::REG_NUM_LEVELS, 20'd3),
            row_w(bplc_pkg::REG_THRESHOLD_1, 20'd0),
            row_w(bplc_pkg::REG_THRESHOLD_2, 20'd2),
            row_w(bplc_pkg::REG_THRESHOLD_3, 20'd4),
            row_w(bplc_pkg::REG_THRESHOLD_4, THR_MAX),
            row_w(REG_SPARE, THR_MAX),
            // A press that climbs through every level and reaches the top.
            row_s(1'b0), row_s(1'b1), row_s(1'b1), row_s(1'b1),
            row_s(1'b1), row_s(1'b1), row_s(1'b1), row_s(1'b0),
            // A one-word release between presses restarts the timer.
            row_s(1'b1), row_s(1'b0), row_s(1'b1),
            // The active level flips while a press is being timed.
            row_w(bplc_pkg::REG_ACTIVE_LEVEL, 20'd0),
            row_s(1'b1), row_s(1'b0), row_s(1'b1),
            // A level count of zero behaves as a single level.
            row_w(bplc_pkg::REG_NUM_LEVELS, 20'd0),
            row_s(1'b0), row_s(1'b0), row_s(1'b1),
            // Thresholds out of order: level two is met before level one.
            row_w(bplc_pkg::REG_NUM_LEVELS, 20'd2),
            row_w(bplc_pkg::REG_THRESHOLD_1, 20'd3),
            row_w(bplc_pkg::REG_THRESHOLD_2, 20'd1),
            row_s(1'b0), row_s(1'b0), row_s(1'b1)
        };

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_WRITE) begin
                drain_results();
                write_register(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            end else begin
                send_sample(dir_rows[k].pin, dir_rows[k].typed, dir_rows[k].want);
            end
        end
        drain_results();

        // Random phases rotate through the idle patterns: none, sender idle,
        // receiver stalling, and both at once.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 60;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 60;
                end
                default: begin
                    src_idle_pct   = 23;
                    sink_stall_pct = 23;
                end
            endcase
            program_phase(phase);
            run_random_phase(PHASE_WORDS);
            drain_results();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- button_press_level_classifier_top.f -----
+incdir+hdl
hdl/bplc_pkg.sv
hdl/button_press_level_classifier_top.sv
tb/sv/button_press_level_classifier_top_tb.sv
